@@ hw/rtl/erp_pkg.sv @@
package erp_pkg;

    // Field widths
    localparam int COORD_W = 10;
    localparam int COL_W   = COORD_W - 3;
    localparam int TIME_W  = 32;
    localparam int CNT16_W = 16;
    localparam int PCT_W   = 7;
    localparam int ACT_W   = 3;
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 32;

    // Result action codes
    localparam logic [ACT_W-1:0] ACT_DEFER   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PARTIAL = 3'd1;
    localparam logic [ACT_W-1:0] ACT_FULL    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_NONE    = 3'd4;

    // Input modes
    localparam logic MODE_FLUSH = 1'b0;
    localparam logic MODE_CHECK = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_PARTIAL_LIMIT  = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_FULL_INTERVAL  = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_CLEAR_INTERVAL = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_MIN_UPDATE     = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_USAGE_LIMIT    = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_USAGE_PERCENT  = 3'd5;

    // Configuration reset values
    localparam logic [CNT16_W-1:0] RST_PARTIAL_LIMIT  = 16'd50;
    localparam logic [TIME_W-1:0]  RST_FULL_INTERVAL  = 32'd300000;
    localparam logic [TIME_W-1:0]  RST_CLEAR_INTERVAL = 32'd1800000;
    localparam logic [TIME_W-1:0]  RST_MIN_UPDATE     = 32'd100;
    localparam logic [CNT16_W-1:0] RST_USAGE_LIMIT    = 16'd1000;
    localparam logic [PCT_W-1:0]   RST_USAGE_PERCENT  = 7'd80;

    // Percentage scale for the total wear compare
    localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;

endpackage

@@ hw/rtl/eink_refresh_policy.sv @@
// E-ink refresh policy with a wear map of PANEL_HEIGHT x ceil(PANEL_WIDTH/8) 16-bit counters
// in one internal memory, updated by a single read-modify-write unit. After reset the block
// runs a clearing pass over all PANEL_HEIGHT*ceil(PANEL_WIDTH/8) cells (9600 at the defaults)
// with s_ready low; configuration writes are taken during it. A flush item reads and writes
// back one wear cell per 8-pixel step from the left edge of each row of its clipped rectangle
// (one cell a cycle through the memory port, then draining the read-modify-write pipeline);
// a rectangle that covers no cell skips the memory. A check item with a clear cycle due
// sweeps the whole memory one cell a cycle. Each item gives one result; the result sits in
// an output register, so a new item is taken while the previous result still waits on
// m_ready. A finished item whose result finds that register still occupied waits until
// m_ready frees it.
module eink_refresh_policy
    import erp_pkg::*;
#(
    parameter int PANEL_WIDTH  = 240,
    parameter int PANEL_HEIGHT = 320
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_wr_en,
    input  logic [CFG_A_W-1:0]   cfg_addr,
    input  logic [CFG_D_W-1:0]   cfg_wdata,
    // input items
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_mode,
    input  logic [TIME_W-1:0]    s_now_ms,
    input  logic [COORD_W-1:0]   s_area_left,
    input  logic [COORD_W-1:0]   s_area_top,
    input  logic [COORD_W-1:0]   s_area_right,
    input  logic [COORD_W-1:0]   s_area_bottom,
    // results
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ACT_W-1:0]     m_action,
    output logic                 m_maintenance_due,
    output logic [CNT16_W-1:0]   m_partial_count_out
);

    localparam int CPR        = (PANEL_WIDTH + 7) / 8;
    localparam int CELL_COUNT = PANEL_HEIGHT * CPR;
    localparam int AW         = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);
    localparam int PROD_W     = PCT_W + CNT16_W;
    localparam int RHS_W      = PROD_W + CNT_W;
    localparam int LHS_W      = TIME_W + PCT_W;
    localparam int CMP_W      = (RHS_W > LHS_W) ? RHS_W : LHS_W;

    typedef enum logic [9:0] {
        ST_SWEEP  = 10'b00_0000_0001,
        ST_IDLE   = 10'b00_0000_0010,
        ST_SETUP  = 10'b00_0000_0100,
        ST_WALK   = 10'b00_0000_1000,
        ST_DECIDE = 10'b00_0001_0000,
        ST_CHECK  = 10'b00_0010_0000,
        ST_MUL1   = 10'b00_0100_0000,
        ST_MUL2   = 10'b00_1000_0000,
        ST_CMP    = 10'b01_0000_0000,
        ST_RESULT = 10'b10_0000_0000
    } state_t;

    // control state
    state_t               state_reg, state_next;
    logic [CNT16_W-1:0]   plimit_reg, plimit_next;
    logic [TIME_W-1:0]    full_int_reg, full_int_next;
    logic [TIME_W-1:0]    clear_int_reg, clear_int_next;
    logic [TIME_W-1:0]    min_upd_reg, min_upd_next;
    logic [CNT16_W-1:0]   ulimit_reg, ulimit_next;
    logic [PCT_W-1:0]     upct_reg, upct_next;
    logic [TIME_W-1:0]    wear_total_reg, wear_total_next;
    logic [CNT16_W-1:0]   pcount_reg, pcount_next;
    logic [TIME_W-1:0]    last_full_reg, last_full_next;
    logic [TIME_W-1:0]    last_clear_reg, last_clear_next;
    logic [TIME_W-1:0]    last_update_reg, last_update_next;
    logic                 mflag_reg, mflag_next;
    logic                 issue_reg, issue_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [AW-1:0]        sweep_addr_reg, sweep_addr_next;
    logic                 sweep_report_reg, sweep_report_next;
    logic                 m_valid_reg, m_valid_next;

    // datapath registers
    logic [TIME_W-1:0]    in_now_reg, in_now_next;
    logic [COORD_W-1:0]   in_left_reg, in_left_next;
    logic [COORD_W-1:0]   in_top_reg, in_top_next;
    logic [COORD_W-1:0]   in_right_reg, in_right_next;
    logic [COORD_W-1:0]   in_bottom_reg, in_bottom_next;
    logic [COORD_W-1:0]   row_reg, row_next;
    logic [COORD_W-1:0]   row_last_reg, row_last_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [COL_W-1:0]     col_first_reg, col_first_next;
    logic [COL_W-1:0]     col_last_reg, col_last_next;
    logic [AW-1:0]        base_reg, base_next;
    logic [AW-1:0]        pend_addr_reg, pend_addr_next;
    logic [ACT_W-1:0]     act_reg, act_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [LHS_W-1:0]     lhs_reg, lhs_next;
    logic [RHS_W-1:0]     rhs_reg, rhs_next;
    logic [ACT_W-1:0]     m_action_reg, m_action_next;
    logic                 m_maint_reg, m_maint_next;
    logic [CNT16_W-1:0]   m_pc_reg, m_pc_next;

    // wear memory
    logic [CNT16_W-1:0]   wear_mem [CELL_COUNT];
    logic [CNT16_W-1:0]   rd_data_reg;
    logic                 mem_rd_en;
    logic [AW-1:0]        mem_rd_addr;
    logic                 mem_wr_en;
    logic [AW-1:0]        mem_wr_addr;
    logic [CNT16_W-1:0]   mem_wr_data;

    // setup arithmetic
    logic                 area_empty;
    logic [COORD_W-1:0]   col_lim;
    logic [COORD_W-1:0]   col_span;
    logic [COORD_W-1:0]   row_lim;

    // cell update
    logic                 cell_sat;
    logic [CNT16_W-1:0]   cell_new;

    // decision
    logic                 want_full;
    logic                 too_soon;
    logic                 clear_due;

    assign s_ready             = (state_reg == ST_IDLE);
    assign m_valid             = m_valid_reg;
    assign m_action            = m_action_reg;
    assign m_maintenance_due   = m_maint_reg;
    assign m_partial_count_out = m_pc_reg;

    // clip the rectangle to the panel
    assign area_empty = (in_top_reg > in_bottom_reg) || (in_left_reg > in_right_reg)
        || ((COORD_W + 1)'(in_top_reg) >= (COORD_W + 1)'(PANEL_HEIGHT))
        || ((COORD_W + 1)'(in_left_reg) >= (COORD_W + 1)'(PANEL_WIDTH));
    assign col_lim  = ((COORD_W + 1)'(in_right_reg) < (COORD_W + 1)'(PANEL_WIDTH))
        ? in_right_reg : COORD_W'(PANEL_WIDTH - 1);
    assign row_lim  = ((COORD_W + 1)'(in_bottom_reg) < (COORD_W + 1)'(PANEL_HEIGHT))
        ? in_bottom_reg : COORD_W'(PANEL_HEIGHT - 1);
    assign col_span = col_lim - in_left_reg;

    // saturating increment of the cell read last cycle
    assign cell_sat = (rd_data_reg == {CNT16_W{1'b1}});
    assign cell_new = cell_sat ? rd_data_reg : rd_data_reg + 1'b1;

    assign want_full = (pcount_reg >= plimit_reg)
        || ((in_now_reg - last_full_reg) >= full_int_reg) || mflag_reg;
    assign too_soon  = (in_now_reg - last_update_reg) < min_upd_reg;
    assign clear_due = (in_now_reg - last_clear_reg) >= clear_int_reg;

    always_comb begin
        state_next        = state_reg;
        plimit_next       = plimit_reg;
        full_int_next     = full_int_reg;
        clear_int_next    = clear_int_reg;
        min_upd_next      = min_upd_reg;
        ulimit_next       = ulimit_reg;
        upct_next         = upct_reg;
        wear_total_next   = wear_total_reg;
        pcount_next       = pcount_reg;
        last_full_next    = last_full_reg;
        last_clear_next   = last_clear_reg;
        last_update_next  = last_update_reg;
        mflag_next        = mflag_reg;
        issue_next        = issue_reg;
        pend_valid_next   = 1'b0;
        sweep_addr_next   = sweep_addr_reg;
        sweep_report_next = sweep_report_reg;
        m_valid_next      = m_valid_reg;
        in_now_next       = in_now_reg;
        in_left_next      = in_left_reg;
        in_top_next       = in_top_reg;
        in_right_next     = in_right_reg;
        in_bottom_next    = in_bottom_reg;
        row_next          = row_reg;
        row_last_next     = row_last_reg;
        col_next          = col_reg;
        col_first_next    = col_first_reg;
        col_last_next     = col_last_reg;
        base_next         = base_reg;
        pend_addr_next    = pend_addr_reg;
        act_next          = act_reg;
        prod_next         = prod_reg;
        lhs_next          = lhs_reg;
        rhs_next          = rhs_reg;
        m_action_next     = m_action_reg;
        m_maint_next      = m_maint_reg;
        m_pc_next         = m_pc_reg;
        mem_rd_en         = 1'b0;
        mem_rd_addr       = base_reg + AW'(col_reg);
        mem_wr_en         = 1'b0;
        mem_wr_addr       = pend_addr_reg;
        mem_wr_data       = cell_new;

        // configuration writes
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_PARTIAL_LIMIT:  plimit_next    = cfg_wdata[CNT16_W-1:0];
                REG_FULL_INTERVAL:  full_int_next  = cfg_wdata[TIME_W-1:0];
                REG_CLEAR_INTERVAL: clear_int_next = cfg_wdata[TIME_W-1:0];
                REG_MIN_UPDATE:     min_upd_next   = cfg_wdata[TIME_W-1:0];
                REG_USAGE_LIMIT:    ulimit_next    = cfg_wdata[CNT16_W-1:0];
                REG_USAGE_PERCENT:  upct_next      = cfg_wdata[PCT_W-1:0];
                default: ;
            endcase
        end

        // drop the result once transferred
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_SWEEP: begin
                // zero one cell a cycle
                mem_wr_en       = 1'b1;
                mem_wr_addr     = sweep_addr_reg;
                mem_wr_data     = '0;
                sweep_addr_next = sweep_addr_reg + 1'b1;
                if (sweep_addr_reg == AW'(CELL_COUNT - 1)) begin
                    sweep_addr_next = '0;
                    state_next      = sweep_report_reg ? ST_MUL1 : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    in_now_next    = s_now_ms;
                    in_left_next   = s_area_left;
                    in_top_next    = s_area_top;
                    in_right_next  = s_area_right;
                    in_bottom_next = s_area_bottom;
                    state_next     = (s_mode == MODE_CHECK) ? ST_CHECK : ST_SETUP;
                end
            end
            ST_SETUP: begin
                row_next       = in_top_reg;
                row_last_next  = row_lim;
                col_next       = in_left_reg[COORD_W-1:3];
                col_first_next = in_left_reg[COORD_W-1:3];
                col_last_next  = in_left_reg[COORD_W-1:3] + col_span[COORD_W-1:3];
                base_next      = AW'(in_top_reg) * AW'(CPR);
                issue_next     = 1'b1;
                state_next     = area_empty ? ST_DECIDE : ST_WALK;
            end
            ST_WALK: begin
                // issue the read of the next cell
                if (issue_reg) begin
                    mem_rd_en       = 1'b1;
                    pend_valid_next = 1'b1;
                    pend_addr_next  = mem_rd_addr;
                    if (col_reg == col_last_reg) begin
                        col_next = col_first_reg;
                        if (row_reg == row_last_reg) begin
                            issue_next = 1'b0;
                        end else begin
                            row_next  = row_reg + 1'b1;
                            base_next = base_reg + AW'(CPR);
                        end
                    end else begin
                        col_next = col_reg + 1'b1;
                    end
                end
                // write back the cell read last cycle
                if (pend_valid_reg) begin
                    mem_wr_en = 1'b1;
                    if (!cell_sat && (wear_total_reg != {TIME_W{1'b1}})) begin
                        wear_total_next = wear_total_reg + 1'b1;
                    end
                    if (cell_new > ulimit_reg) begin
                        mflag_next = 1'b1;
                    end
                end
                if (!issue_reg && !pend_valid_reg) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                priority if (too_soon) begin
                    act_next = ACT_DEFER;
                end else if (want_full) begin
                    act_next         = ACT_FULL;
                    pcount_next      = '0;
                    last_full_next   = in_now_reg;
                    mflag_next       = 1'b0;
                    last_update_next = in_now_reg;
                end else begin
                    act_next = ACT_PARTIAL;
                    if (pcount_reg != {CNT16_W{1'b1}}) begin
                        pcount_next = pcount_reg + 1'b1;
                    end
                    last_update_next = in_now_reg;
                end
                state_next = ST_RESULT;
            end
            ST_CHECK: begin
                if (clear_due) begin
                    act_next          = ACT_CLEAR;
                    wear_total_next   = '0;
                    pcount_next       = '0;
                    last_clear_next   = in_now_reg;
                    sweep_report_next = 1'b1;
                    state_next        = ST_SWEEP;
                end else begin
                    act_next   = ACT_NONE;
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: begin
                prod_next  = PROD_W'(upct_reg) * PROD_W'(ulimit_reg);
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                lhs_next   = LHS_W'(wear_total_reg) * LHS_W'(PCT_SCALE);
                rhs_next   = RHS_W'(prod_reg) * RHS_W'(CELL_COUNT);
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (CMP_W'(lhs_reg) > CMP_W'(rhs_reg)) begin
                    mflag_next = 1'b1;
                end
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_action_next     = act_reg;
                    m_maint_next      = mflag_reg;
                    m_pc_next         = pcount_reg;
                    sweep_report_next = 1'b0;
                    state_next        = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_SWEEP;
            plimit_reg       <= RST_PARTIAL_LIMIT;
            full_int_reg     <= RST_FULL_INTERVAL;
            clear_int_reg    <= RST_CLEAR_INTERVAL;
            min_upd_reg      <= RST_MIN_UPDATE;
            ulimit_reg       <= RST_USAGE_LIMIT;
            upct_reg         <= RST_USAGE_PERCENT;
            wear_total_reg   <= '0;
            pcount_reg       <= '0;
            last_full_reg    <= '0;
            last_clear_reg   <= '0;
            last_update_reg  <= '0;
            mflag_reg        <= 1'b0;
            issue_reg        <= 1'b0;
            pend_valid_reg   <= 1'b0;
            sweep_addr_reg   <= '0;
            sweep_report_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            plimit_reg       <= plimit_next;
            full_int_reg     <= full_int_next;
            clear_int_reg    <= clear_int_next;
            min_upd_reg      <= min_upd_next;
            ulimit_reg       <= ulimit_next;
            upct_reg         <= upct_next;
            wear_total_reg   <= wear_total_next;
            pcount_reg       <= pcount_next;
            last_full_reg    <= last_full_next;
            last_clear_reg   <= last_clear_next;
            last_update_reg  <= last_update_next;
            mflag_reg        <= mflag_next;
            issue_reg        <= issue_next;
            pend_valid_reg   <= pend_valid_next;
            sweep_addr_reg   <= sweep_addr_next;
            sweep_report_reg <= sweep_report_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        in_now_reg    <= in_now_next;
        in_left_reg   <= in_left_next;
        in_top_reg    <= in_top_next;
        in_right_reg  <= in_right_next;
        in_bottom_reg <= in_bottom_next;
        row_reg       <= row_next;
        row_last_reg  <= row_last_next;
        col_reg       <= col_next;
        col_first_reg <= col_first_next;
        col_last_reg  <= col_last_next;
        base_reg      <= base_next;
        pend_addr_reg <= pend_addr_next;
        act_reg       <= act_next;
        prod_reg      <= prod_next;
        lhs_reg       <= lhs_next;
        rhs_reg       <= rhs_next;
        m_action_reg  <= m_action_next;
        m_maint_reg   <= m_maint_next;
        m_pc_reg      <= m_pc_next;
    end

    // wear memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            wear_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            rd_data_reg <= wear_mem[mem_rd_addr];
        end
    end

endmodule

@@ hw/rtl/erp_checker.sv @@
module erp_checker
    import erp_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [ACT_W-1:0]     m_action,
    input logic                 m_maintenance_due,
    input logic [CNT16_W-1:0]   m_partial_count_out
);

    // busy after every input transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while block busy");

    // action code is always a defined one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_action == ACT_DEFER || m_action == ACT_PARTIAL
            || m_action == ACT_FULL || m_action == ACT_CLEAR || m_action == ACT_NONE))
        else $error("undefined action code");

    // full refresh resets the partial count and maintenance
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_action == ACT_FULL) |-> (!m_maintenance_due && m_partial_count_out == '0))
        else $error("full refresh left count or maintenance set");

    // clear cycle resets the partial count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_action == ACT_CLEAR) |-> (m_partial_count_out == '0))
        else $error("clear cycle left partial count set");

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_action)
            && $stable(m_maintenance_due) && $stable(m_partial_count_out)))
        else $error("stalled result changed");

endmodule

bind eink_refresh_policy erp_checker u_erp_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .s_valid             (s_valid),
    .s_ready             (s_ready),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_action            (m_action),
    .m_maintenance_due   (m_maintenance_due),
    .m_partial_count_out (m_partial_count_out)
);

@@ tb/eink_refresh_policy_tb.sv @@
`timescale 1ns / 1ps

module eink_refresh_policy_tb;
    import erp_pkg::*;

    localparam int PANEL_WIDTH    = 240;
    localparam int PANEL_HEIGHT   = 320;
    localparam int CELLS_PER_ROW  = (PANEL_WIDTH + 7) / 8;
    localparam int CELL_COUNT     = PANEL_HEIGHT * CELLS_PER_ROW;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int ITEMS_PER_PHASE = 20;
    localparam int PHASE_COUNT     = 5;

    typedef struct {
        logic               mode;
        logic [TIME_W-1:0]  now_ms;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
    } policy_item_t;

    typedef struct {
        logic [ACT_W-1:0]   action;
        logic               maint;
        logic [CNT16_W-1:0] pcount;
    } policy_result_t;

    typedef struct {
        policy_item_t   item;
        bit             typed;
        policy_result_t want;
    } table_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_A_W-1:0]   cfg_addr;
    logic [CFG_D_W-1:0]   cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_mode;
    logic [TIME_W-1:0]    s_now_ms;
    logic [COORD_W-1:0]   s_area_left;
    logic [COORD_W-1:0]   s_area_top;
    logic [COORD_W-1:0]   s_area_right;
    logic [COORD_W-1:0]   s_area_bottom;
    logic                 m_valid;
    logic                 m_ready;
    logic [ACT_W-1:0]     m_action;
    logic                 m_maintenance_due;
    logic [CNT16_W-1:0]   m_partial_count_out;

    // policy settings as the block should hold them
    logic [CNT16_W-1:0]   lim_partial;
    logic [TIME_W-1:0]    ivl_full;
    logic [TIME_W-1:0]    ivl_clear;
    logic [TIME_W-1:0]    ivl_min_update;
    logic [CNT16_W-1:0]   lim_usage;
    logic [PCT_W-1:0]     pct_usage;

    // panel state as the block should hold it
    logic [CNT16_W-1:0]   wear_map [CELL_COUNT];
    logic [TIME_W-1:0]    wear_sum;
    logic [CNT16_W-1:0]   refresh_count;
    logic [TIME_W-1:0]    last_full_ms;
    logic [TIME_W-1:0]    last_clear_ms;
    logic [TIME_W-1:0]    last_update_ms;
    logic                 maint_flag;

    policy_result_t       expected_results[$];
    policy_result_t       oldest_result;
    table_row_t           directed_rows[$];
    logic [TIME_W-1:0]    sim_ms;
    bit                   steady_flow;
    int                   ready_hold;
    int                   quiet_cycles;
    int                   mismatch_count;

    eink_refresh_policy #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) DUT (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_addr            (cfg_addr),
        .cfg_wdata           (cfg_wdata),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_mode              (s_mode),
        .s_now_ms            (s_now_ms),
        .s_area_left         (s_area_left),
        .s_area_top          (s_area_top),
        .s_area_right        (s_area_right),
        .s_area_bottom       (s_area_bottom),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_action            (m_action),
        .m_maintenance_due   (m_maintenance_due),
        .m_partial_count_out (m_partial_count_out)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Work out the refresh decision for one accepted item and advance the panel state
    function automatic policy_result_t decide_refresh(input policy_item_t it);
        policy_result_t     res;
        int                 y;
        int                 x;
        int                 cell_idx;
        logic               full_due;
        logic [TIME_W-1:0]  since_full;
        logic [TIME_W-1:0]  since_update;
        logic [TIME_W-1:0]  since_clear;
        since_full   = it.now_ms - last_full_ms;
        since_update = it.now_ms - last_update_ms;
        since_clear  = it.now_ms - last_clear_ms;
        if (it.mode == MODE_FLUSH) begin
            // wear one cell per byte column, stepping by 8 pixels from the left edge
            if (it.top <= it.bottom && it.left <= it.right) begin
                for (y = it.top; y <= it.bottom && y < PANEL_HEIGHT; y++) begin
                    for (x = it.left; x <= it.right && x < PANEL_WIDTH; x += 8) begin
                        cell_idx = y * CELLS_PER_ROW + x / 8;
                        if (wear_map[cell_idx] != '1) begin
                            wear_map[cell_idx] = wear_map[cell_idx] + 1'b1;
                            if (wear_sum != '1)
                                wear_sum = wear_sum + 1'b1;
                        end
                        if (wear_map[cell_idx] > lim_usage)
                            maint_flag = 1'b1;
                    end
                end
            end
            full_due = (refresh_count >= lim_partial) || (since_full >= ivl_full) || maint_flag;
            if (since_update < ivl_min_update) begin
                res.action = ACT_DEFER;
            end else if (full_due) begin
                res.action     = ACT_FULL;
                refresh_count  = '0;
                last_full_ms   = it.now_ms;
                last_update_ms = it.now_ms;
                maint_flag     = 1'b0;
            end else begin
                res.action = ACT_PARTIAL;
                if (refresh_count != '1)
                    refresh_count = refresh_count + 1'b1;
                last_update_ms = it.now_ms;
            end
        end else begin
            res.action = ACT_NONE;
            if (since_clear >= ivl_clear) begin
                foreach (wear_map[i])
                    wear_map[i] = '0;
                wear_sum      = '0;
                refresh_count = '0;
                last_clear_ms = it.now_ms;
                res.action    = ACT_CLEAR;
            end
            if (64'(wear_sum) * 64'(PCT_SCALE) >
                64'(pct_usage) * 64'(CELL_COUNT) * 64'(lim_usage))
                maint_flag = 1'b1;
        end
        res.maint  = maint_flag;
        res.pcount = refresh_count;
        return res;
    endfunction

    function automatic void table_row(input logic mode, input logic [TIME_W-1:0] now_ms,
                                      input logic [COORD_W-1:0] left,
                                      input logic [COORD_W-1:0] top,
                                      input logic [COORD_W-1:0] right,
                                      input logic [COORD_W-1:0] bottom,
                                      input bit typed, input logic [ACT_W-1:0] action,
                                      input logic maint, input logic [CNT16_W-1:0] pcount);
        table_row_t row;
        row.item.mode   = mode;
        row.item.now_ms = now_ms;
        row.item.left   = left;
        row.item.top    = top;
        row.item.right  = right;
        row.item.bottom = bottom;
        row.typed       = typed;
        row.want.action = action;
        row.want.maint  = maint;
        row.want.pcount = pcount;
        directed_rows.push_back(row);
    endfunction

    // Write one setting and mirror it in the predictor
    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_PARTIAL_LIMIT:  lim_partial    = data[CNT16_W-1:0];
            REG_FULL_INTERVAL:  ivl_full       = data;
            REG_CLEAR_INTERVAL: ivl_clear      = data;
            REG_MIN_UPDATE:     ivl_min_update = data;
            REG_USAGE_LIMIT:    lim_usage      = data[CNT16_W-1:0];
            REG_USAGE_PERCENT:  pct_usage      = data[PCT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_policy(input logic [CNT16_W-1:0] partial_limit,
                                  input logic [TIME_W-1:0] full_ms,
                                  input logic [TIME_W-1:0] clear_ms,
                                  input logic [TIME_W-1:0] min_ms,
                                  input logic [CNT16_W-1:0] usage_limit,
                                  input logic [PCT_W-1:0] usage_percent);
        write_reg(REG_PARTIAL_LIMIT, CFG_D_W'(partial_limit));
        write_reg(REG_FULL_INTERVAL, full_ms);
        write_reg(REG_CLEAR_INTERVAL, clear_ms);
        write_reg(REG_MIN_UPDATE, min_ms);
        write_reg(REG_USAGE_LIMIT, CFG_D_W'(usage_limit));
        write_reg(REG_USAGE_PERCENT, CFG_D_W'(usage_percent));
    endtask

    // Drop valid and hold off until every expected result has come back
    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge aclk);
    endtask

    // Offer one item, wait for its transfer, then queue its expected result
    task automatic send_item(input policy_item_t it, input bit typed,
                             input policy_result_t want);
        int             gap;
        policy_result_t got;
        @(negedge aclk);
        if (!steady_flow && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            gap = $urandom_range(1, 9);
            repeat (gap) @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_mode        = it.mode;
        s_now_ms      = it.now_ms;
        s_area_left   = it.left;
        s_area_top    = it.top;
        s_area_right  = it.right;
        s_area_bottom = it.bottom;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        got = decide_refresh(it);
        if (typed)
            expected_results.push_back(want);
        else
            expected_results.push_back(got);
    endtask

    // Stall the result channel in random bursts
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold--;
            m_ready = 1'b0;
        end else if (!steady_flow && $urandom_range(0, 4) == 0) begin
            m_ready    = 1'b0;
            ready_hold = $urandom_range(0, 8);
        end else begin
            m_ready = 1'b1;
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected: action %0d", m_action);
                mismatch_count++;
            end else begin
                oldest_result = expected_results.pop_front();
                if (m_action !== oldest_result.action) begin
                    $error("action: expected %0d, got %0d", oldest_result.action, m_action);
                    mismatch_count++;
                end
                if (m_maintenance_due !== oldest_result.maint) begin
                    $error("maintenance_due: expected %0d, got %0d",
                           oldest_result.maint, m_maintenance_due);
                    mismatch_count++;
                end
                if (m_partial_count_out !== oldest_result.pcount) begin
                    $error("partial_count_out: expected %0d, got %0d",
                           oldest_result.pcount, m_partial_count_out);
                    mismatch_count++;
                end
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("eink_refresh_policy_tb: errors");
            $finish;
        end
    end

    initial begin
        policy_item_t       it;
        policy_result_t     none_typed;
        logic [COORD_W-1:0] swap_tmp;
        int                 phase;
        int                 n;
        int                 sel;
        int                 hop;

        aclk           = 1'b0;
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_addr       = '0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_mode         = MODE_FLUSH;
        s_now_ms       = '0;
        s_area_left    = '0;
        s_area_top     = '0;
        s_area_right   = '0;
        s_area_bottom  = '0;
        m_ready        = 1'b0;
        ready_hold     = 0;
        quiet_cycles   = 0;
        mismatch_count = 0;
        steady_flow    = 1'b0;
        sim_ms         = '0;
        none_typed     = '{ACT_NONE, 1'b0, '0};

        // predictor starts from the reset state
        lim_partial    = RST_PARTIAL_LIMIT;
        ivl_full       = RST_FULL_INTERVAL;
        ivl_clear      = RST_CLEAR_INTERVAL;
        ivl_min_update = RST_MIN_UPDATE;
        lim_usage      = RST_USAGE_LIMIT;
        pct_usage      = RST_USAGE_PERCENT;
        foreach (wear_map[i])
            wear_map[i] = '0;
        wear_sum       = '0;
        refresh_count  = '0;
        last_full_ms   = '0;
        last_clear_ms  = '0;
        last_update_ms = '0;
        maint_flag     = 1'b0;

        // directed items at reset settings: mode, now, left, top, right, bottom, typed, result
        table_row(MODE_FLUSH, 32'd0,       10'd0,    10'd0,    10'd7,    10'd0,
                  1'b1, ACT_DEFER,   1'b0, 16'd0);
        table_row(MODE_FLUSH, 32'd100,     10'd0,    10'd0,    10'd0,    10'd0,
                  1'b1, ACT_PARTIAL, 1'b0, 16'd1);
        table_row(MODE_FLUSH, 32'd150,     10'd0,    10'd0,    10'd0,    10'd0,
                  1'b1, ACT_DEFER,   1'b0, 16'd1);
        table_row(MODE_FLUSH, 32'd250,     10'd0,    10'd5,    10'd100,  10'd4,
                  1'b0, ACT_NONE,    1'b0, 16'd0);
        table_row(MODE_FLUSH, 32'd400,     10'd9,    10'd0,    10'd8,    10'd9,
                  1'b0, ACT_NONE,    1'b0, 16'd0);
        table_row(MODE_FLUSH, 32'd500,     10'd240,  10'd320,  10'd1023, 10'd1023,
                  1'b0, ACT_NONE,    1'b0, 16'd0);
        table_row(MODE_FLUSH, 32'd600,     10'd1023, 10'd1023, 10'd1023, 10'd1023,
                  1'b0, ACT_NONE,    1'b0, 16'd0);
        table_row(MODE_FLUSH, 32'd700,     10'd5,    10'd0,    10'd12,   10'd1,
                  1'b0, ACT_NONE,    1'b0, 16'd0);
        table_row(MODE_FLUSH, 32'd800,     10'd230,  10'd310,  10'd1023, 10'd1023,
                  1'b0, ACT_NONE,    1'b0, 16'd0);
        table_row(MODE_FLUSH, 32'd300000,  10'd0,    10'd0,    10'd0,    10'd0,
                  1'b1, ACT_FULL,    1'b0, 16'd0);
        table_row(MODE_CHECK, 32'd1000000, 10'd1023, 10'd1023, 10'd1023, 10'd1023,
                  1'b1, ACT_NONE,    1'b0, 16'd0);
        table_row(MODE_CHECK, 32'd1800000, 10'd0,    10'd0,    10'd0,    10'd0,
                  1'b1, ACT_CLEAR,   1'b0, 16'd0);
        table_row(MODE_FLUSH, 32'hFFFF_FFFF, 10'd0,  10'd0,    10'd15,   10'd1,
                  1'b1, ACT_FULL,    1'b0, 16'd0);
        table_row(MODE_FLUSH, 32'h0000_0010, 10'd0,  10'd0,    10'd0,    10'd1023,
                  1'b1, ACT_DEFER,   1'b0, 16'd0);
        table_row(MODE_FLUSH, 32'd1000,    10'd0,    10'd0,    10'd1023, 10'd1023,
                  1'b0, ACT_NONE,    1'b0, 16'd0);
        table_row(MODE_CHECK, 32'd2000,    10'd0,    10'd0,    10'd0,    10'd0,
                  1'b0, ACT_NONE,    1'b0, 16'd0);

        // hold reset, then let the block run its clearing pass behind s_ready
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        sim_ms = 32'd3000;

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            drain_results();
            case (phase)
                0: program_policy(16'd3, 32'd5000, 32'd20000, 32'd50, 16'd2, 7'd1);
                1: program_policy(16'd0, 32'd0, 32'd0, 32'd0, 16'd0, 7'd0);
                2: program_policy(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  16'hFFFF, 7'd100);
                default: program_policy(CNT16_W'($urandom_range(0, 8)),
                                        $urandom_range(0, 3000), $urandom_range(0, 8000),
                                        $urandom_range(0, 200),
                                        CNT16_W'($urandom_range(0, 5)),
                                        PCT_W'($urandom_range(0, 100)));
            endcase
            // the closing phase runs with no idling on either side
            steady_flow = (phase == PHASE_COUNT - 1);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (!steady_flow && $urandom_range(0, 14) == 0)
                    drain_results();
                // advance time mostly in small steps, with an occasional jump anywhere
                hop = $urandom_range(0, 9);
                if (hop < 6)
                    sim_ms = sim_ms + $urandom_range(0, 200);
                else if (hop < 9)
                    sim_ms = sim_ms + $urandom_range(0, 6000);
                else
                    sim_ms = $urandom();
                it.now_ms = sim_ms;
                it.mode   = MODE_FLUSH;
                sel       = $urandom_range(0, 99);
                if (sel < 12) begin
                    it.mode   = MODE_CHECK;
                    it.left   = $urandom();
                    it.top    = $urandom();
                    it.right  = $urandom();
                    it.bottom = $urandom();
                end else if (sel < 17) begin
                    // near-whole panel, right and bottom edges at or past the panel bounds
                    it.left   = $urandom_range(0, 7);
                    it.top    = $urandom_range(0, 3);
                    it.right  = $urandom_range(PANEL_WIDTH - 1, 1023);
                    it.bottom = $urandom_range(PANEL_HEIGHT - 1, 1023);
                end else if (sel < 27) begin
                    it.left   = $urandom();
                    it.top    = $urandom();
                    it.right  = $urandom();
                    it.bottom = $urandom();
                end else begin
                    // small area, half of them on a hot corner to build up wear
                    if ($urandom_range(0, 1) == 0) begin
                        it.top  = $urandom_range(0, 3);
                        it.left = $urandom_range(0, 15);
                    end else begin
                        it.top  = $urandom_range(0, PANEL_HEIGHT + 3);
                        it.left = $urandom_range(0, PANEL_WIDTH + 10);
                    end
                    it.bottom = it.top + $urandom_range(0, 4);
                    it.right  = it.left + $urandom_range(0, 31);
                    if (sel >= 95) begin
                        swap_tmp = it.left;
                        it.left  = it.right;
                        it.right = swap_tmp;
                    end
                end
                send_item(it, 1'b0, none_typed);
            end
        end

        drain_results();
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("eink_refresh_policy_tb: clean");
        else
            $display("eink_refresh_policy_tb: errors");
        $finish;
    end

endmodule
